FILE: hdl/wsd_pkg.sv
// ---------------------------------------------------------------------------
// WebSocket deframer package
// Shared widths, result kinds and the record that passes from the header
// parser to the output stage.
// ---------------------------------------------------------------------------
package wsd_pkg;

    localparam int LEN_WIDTH   = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_EMPTY     = 3'd1;
    localparam logic [2:0] KIND_UNMASKED  = 3'd2;
    localparam logic [2:0] KIND_TRUNCATED = 3'd3;
    localparam logic [2:0] KIND_PING_LONG = 3'd4;

    localparam logic [3:0] OPCODE_PING = 4'h9;
    localparam logic [6:0] LEN7_EXT16  = 7'd126;
    localparam logic [6:0] LEN7_EXT64  = 7'd127;
    localparam logic [6:0] PING_MAX    = 7'd125;

    // One pending result: raw byte and key byte are combined in the back end.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [7:0] key_byte;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } wsd_entry_t;

endpackage

FILE: hdl/wsd_front.sv
// ---------------------------------------------------------------------------
// WebSocket deframer front end
// Parses the frame header one byte per beat and classifies every byte,
// producing at most one result record for the queue.
// ---------------------------------------------------------------------------
module wsd_front
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_in,
    input  logic       buffer_end,
    output logic       push,
    output wsd_entry_t entry
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]           phase_reg, phase_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [3:0]           opcode_reg, opcode_next;
    logic                 fin_reg, fin_next;
    logic [LEN_WIDTH-1:0] left_reg, left_next;
    logic [31:0]          key_reg, key_next;
    logic [1:0]           kidx_reg, kidx_next;
    logic                 disc_reg, disc_next;

    logic                 emit;
    logic [2:0]           emit_kind;
    logic [7:0]           emit_data;
    logic [7:0]           emit_key;
    logic                 emit_last;
    logic [LEN_WIDTH-1:0] ext_len;
    logic [LEN_WIDTH-1:0] left_dec;
    logic [7:0]           key_sel;

    function automatic logic ping_too_long(input logic [3:0] opc,
                                           input logic [LEN_WIDTH-1:0] len);
        ping_too_long = (opc == OPCODE_PING) && (len > LEN_WIDTH'(PING_MAX));
    endfunction

    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_sel = key_reg[31:24];
            2'd1:    key_sel = key_reg[23:16];
            2'd2:    key_sel = key_reg[15:8];
            default: key_sel = key_reg[7:0];
        endcase
    end

    // Extended length shifts in big-endian and sticks at all ones on overflow.
    assign ext_len  = (left_reg[LEN_WIDTH-1 -: 8] != 8'd0) ? '1
                                                          : {left_reg[LEN_WIDTH-9:0], data_in};
    assign left_dec = (left_reg != '0) ? left_reg - LEN_WIDTH'(1) : left_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        left_next   = left_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        disc_next   = disc_reg;
        emit        = 1'b0;
        emit_kind   = KIND_PAYLOAD;
        emit_data   = 8'd0;
        emit_key    = 8'd0;
        emit_last   = 1'b1;

        if (fire && !disc_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = data_in[3:0];
                    fin_next    = data_in[7];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (!data_in[7])
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_UNMASKED;
                        disc_next = 1'b1;
                    end
                    else if (data_in[6:0] == LEN7_EXT16)
                    begin
                        left_next  = '0;
                        cnt_next   = 3'd1;
                        phase_next = PH_EXTLEN;
                    end
                    else if (data_in[6:0] == LEN7_EXT64)
                    begin
                        left_next  = '0;
                        cnt_next   = 3'd7;
                        phase_next = PH_EXTLEN;
                    end
                    else
                    begin
                        left_next = LEN_WIDTH'(data_in[6:0]);
                        if (ping_too_long(opcode_reg, LEN_WIDTH'(data_in[6:0])))
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_PING_LONG;
                            disc_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_KEY;
                            kidx_next  = 2'd0;
                            key_next   = '0;
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    left_next = ext_len;
                    if (cnt_reg == 3'd0)
                    begin
                        if (ping_too_long(opcode_reg, ext_len))
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_PING_LONG;
                            disc_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_KEY;
                            kidx_next  = 2'd0;
                            key_next   = '0;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], data_in};
                    if (kidx_reg == 2'd3)
                    begin
                        kidx_next = 2'd0;
                        if (left_reg == '0)
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_EMPTY;
                            disc_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        kidx_next = kidx_reg + 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    kidx_next = kidx_reg + 2'd1;
                    left_next = left_dec;
                    if (!buffer_end || left_dec == '0)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_PAYLOAD;
                        emit_data = data_in;
                        emit_key  = key_sel;
                        emit_last = (left_dec == '0);
                    end
                    if (left_dec == '0)
                    begin
                        disc_next = 1'b1;
                    end
                end
                default:
                begin
                    disc_next = 1'b1;
                end
            endcase

            // A buffer that ends before its frame is complete reports truncation.
            if (buffer_end && !emit && !disc_next)
            begin
                emit      = 1'b1;
                emit_kind = KIND_TRUNCATED;
                emit_data = 8'd0;
                emit_key  = 8'd0;
                emit_last = 1'b1;
            end
        end

        entry.kind     = emit_kind;
        entry.data     = emit_data;
        entry.key_byte = emit_key;
        entry.opcode   = opcode_next;
        entry.fin      = fin_next;
        entry.last     = emit_last;
        push           = emit;

        // Every buffer end returns the parser to the first header byte.
        if (fire && buffer_end)
        begin
            phase_next  = PH_HDR0;
            cnt_next    = 3'd0;
            opcode_next = 4'd0;
            fin_next    = 1'b0;
            left_next   = '0;
            key_next    = '0;
            kidx_next   = 2'd0;
            disc_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            cnt_reg    <= 3'd0;
            opcode_reg <= 4'd0;
            fin_reg    <= 1'b0;
            left_reg   <= '0;
            key_reg    <= '0;
            kidx_reg   <= 2'd0;
            disc_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            left_reg   <= left_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            disc_reg   <= disc_next;
        end
    end

    // While payload is still streaming, at least one byte remains.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD && !disc_reg) |-> (left_reg != '0))
        else $error("payload phase with no bytes left");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && buffer_end) |=> (phase_reg == PH_HDR0 && !disc_reg && kidx_reg == 2'd0))
        else $error("buffer end did not restart the parser");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HDR0) |-> (kidx_reg == 2'd0 && left_reg == '0))
        else $error("stale frame state at first header byte");

endmodule

FILE: hdl/wsd_queue.sv
// ---------------------------------------------------------------------------
// WebSocket deframer result queue
// Small FIFO that decouples the header parser from the output stage.
// ---------------------------------------------------------------------------
module wsd_queue
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  wsd_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output wsd_entry_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    wsd_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/wsd_back.sv
// ---------------------------------------------------------------------------
// WebSocket deframer back end
// Unmasks payload bytes and holds each result in the output register until
// the receiver takes it.
// ---------------------------------------------------------------------------
module wsd_back
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       not_empty,
    input  wsd_entry_t head,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [2:0] kind,
    output logic [7:0] data_out,
    output logic [3:0] frame_opcode,
    output logic       final_fragment,
    output logic       frame_last
);

    logic       valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] data_reg;
    logic [3:0] opcode_reg;
    logic       fin_reg;
    logic       last_reg;
    logic [7:0] data_next;

    assign pop       = not_empty && (!valid_reg || !result_stall);
    assign data_next = (head.kind == KIND_PAYLOAD) ? (head.data ^ head.key_byte) : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= head.kind;
            data_reg   <= data_next;
            opcode_reg <= head.opcode;
            fin_reg    <= head.fin;
            last_reg   <= head.last;
        end
    end

    assign result_valid   = valid_reg;
    assign kind           = kind_reg;
    assign data_out       = data_reg;
    assign frame_opcode   = opcode_reg;
    assign final_fragment = fin_reg;
    assign frame_last     = last_reg;

endmodule

FILE: hdl/websocket_frame_deframer.sv
// ---------------------------------------------------------------------------
// WebSocket frame deframer
// Parses one masked client frame per buffer and streams unmasked payload.
// ---------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  -------   --------------------------   ----------------------------------
//  byte      byte_valid / byte_stall      data_in, buffer_end
//  result    result_valid / result_stall  kind, data_out, frame_opcode,
//                                         final_fragment, frame_last
//
//  One byte is accepted per cycle unless byte_stall is high.
//  The parser and the output register are separated by a four-entry queue.
//  byte_stall rises only when that queue is full.
//  Reset (rst_n low) returns the parser to the first header byte and
//  empties the queue and the output register.
// ---------------------------------------------------------------------------
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_in,
    input  logic       buffer_end,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [2:0] kind,
    output logic [7:0] data_out,
    output logic [3:0] frame_opcode,
    output logic       final_fragment,
    output logic       frame_last
);

    logic       fire;
    logic       push;
    logic       pop;
    logic       full;
    logic       not_empty;
    wsd_entry_t push_entry;
    wsd_entry_t head;

    assign byte_stall = full;
    assign fire       = byte_valid && !full;

    wsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .data_in    (data_in),
        .buffer_end (buffer_end),
        .push       (push),
        .entry      (push_entry)
    );

    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    wsd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .not_empty      (not_empty),
        .head           (head),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .data_out       (data_out),
        .frame_opcode   (frame_opcode),
        .final_fragment (final_fragment),
        .frame_last     (frame_last)
    );

endmodule

FILE: test/tb_websocket_frame_deframer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Sends well-formed client frames, broken and unmasked frames and noise one
// beat at a time, predicts every result beat from a software copy of the
// frame parser, and compares each result beat field by field. Both channels
// see random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;
    localparam int DRAIN_CYCLES = 8;
    localparam int BYTE_TARGET  = 1850;
    localparam int REPORT_LIMIT = 10;

    localparam int FORM_SHORT = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    typedef enum logic [2:0] {
        PH_FIRST_HDR,
        PH_SECOND_HDR,
        PH_EXT_LEN,
        PH_MASK_KEY,
        PH_PAYLOAD
    } parse_phase_t;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } deframe_result_t;

    class frame_scoreboard;
        parse_phase_t          phase;
        logic [2:0]            len_bytes_left;
        logic [3:0]            opcode;
        logic                  fin;
        logic [LEN_WIDTH-1:0]  remaining;
        logic [31:0]           key;
        logic [1:0]            key_pos;
        bit                    dropping;
        deframe_result_t       expected_q[$];
        int                    mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            phase          = PH_FIRST_HDR;
            len_bytes_left = '0;
            opcode         = '0;
            fin            = 1'b0;
            remaining      = '0;
            key            = '0;
            key_pos        = '0;
            dropping       = 1'b0;
        endfunction

        function void push(logic [2:0] kind, logic [7:0] data, logic last);
            deframe_result_t res;
            res.kind   = kind;
            res.data   = data;
            res.opcode = opcode;
            res.fin    = fin;
            res.last   = last;
            expected_q.push_back(res);
        endfunction

        // Length is complete: a long ping ends the frame, anything else
        // moves on to the masking key.
        function bit length_complete();
            if (opcode == OPCODE_PING && remaining > PING_MAX)
            begin
                push(KIND_PING_LONG, 8'h00, 1'b1);
                dropping = 1'b1;
                return 1'b1;
            end
            phase   = PH_MASK_KEY;
            key_pos = '0;
            key     = '0;
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, logic last_in_buffer);
            bit         produced;
            logic [7:0] key_byte;
            produced = 1'b0;
            if (dropping)
            begin
                if (last_in_buffer)
                    clear();
                return;
            end
            case (phase)
                PH_FIRST_HDR:
                begin
                    opcode = b[3:0];
                    fin    = b[7];
                    phase  = PH_SECOND_HDR;
                end
                PH_SECOND_HDR:
                begin
                    if (!b[7])
                    begin
                        push(KIND_UNMASKED, 8'h00, 1'b1);
                        dropping = 1'b1;
                        produced = 1'b1;
                    end
                    else if (b[6:0] == LEN7_EXT16)
                    begin
                        remaining      = '0;
                        len_bytes_left = 3'd1;
                        phase          = PH_EXT_LEN;
                    end
                    else if (b[6:0] == LEN7_EXT64)
                    begin
                        remaining      = '0;
                        len_bytes_left = 3'd7;
                        phase          = PH_EXT_LEN;
                    end
                    else
                    begin
                        remaining = LEN_WIDTH'(b[6:0]);
                        produced  = length_complete();
                    end
                end
                PH_EXT_LEN:
                begin
                    if (remaining > (LEN_MAX >> 8))
                        remaining = LEN_MAX;
                    else
                        remaining = (remaining << 8) | LEN_WIDTH'(b);
                    if (len_bytes_left == 0)
                        produced = length_complete();
                    else
                        len_bytes_left = len_bytes_left - 3'd1;
                end
                PH_MASK_KEY:
                begin
                    key = {key[23:0], b};
                    if (key_pos == 2'd3)
                    begin
                        key_pos = '0;
                        if (remaining == 0)
                        begin
                            push(KIND_EMPTY, 8'h00, 1'b1);
                            dropping = 1'b1;
                            produced = 1'b1;
                        end
                        else
                            phase = PH_PAYLOAD;
                    end
                    else
                        key_pos = key_pos + 2'd1;
                end
                PH_PAYLOAD:
                begin
                    // The first key byte received masks payload byte 0.
                    key_byte = 8'(key >> (8 * (3 - int'(key_pos))));
                    key_pos  = key_pos + 2'd1;
                    if (remaining != 0)
                        remaining = remaining - 1'b1;
                    if (remaining == 0 || !last_in_buffer)
                    begin
                        push(KIND_PAYLOAD, b ^ key_byte, remaining == 0);
                        produced = 1'b1;
                    end
                    if (remaining == 0)
                        dropping = 1'b1;
                end
                default:
                    dropping = 1'b1;
            endcase
            // A buffer that ends before its frame is done reports truncation
            // in place of whatever this beat would have given.
            if (last_in_buffer)
            begin
                if (!produced && !dropping)
                    push(KIND_TRUNCATED, 8'h00, 1'b1);
                clear();
            end
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] data,
                                   logic [3:0] op, logic fin_bit, logic last);
            deframe_result_t exp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"unexpected result beat: kind %0d data %02h ",
                              "opcode %0h fin %0b last %0b"},
                             kind, data, op, fin_bit, last);
                return;
            end
            exp = expected_q.pop_front();
            if (kind !== exp.kind || data !== exp.data || op !== exp.opcode ||
                fin_bit !== exp.fin || last !== exp.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result mismatch (exp/act): kind %0d/%0d data %02h/%02h ",
                              "opcode %0h/%0h fin %0b/%0b last %0b/%0b"},
                             exp.kind, kind, exp.data, data, exp.opcode, op,
                             exp.fin, fin_bit, exp.last, last);
            end
        endfunction

        function int pending_count();
            return expected_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    logic [7:0] data_in;
    logic       buffer_end;
    logic       result_valid;
    logic       result_stall;
    logic [2:0] kind;
    logic [7:0] data_out;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       frame_last;

    frame_scoreboard sb;
    logic [7:0]      buf_q[$];
    int              gap_mode;
    int              bytes_sent;
    int              stall_run;
    int              rx_cycles;
    bit              quiet_rx;

    websocket_frame_deframer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_in        (data_in),
        .buffer_end     (buffer_end),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .data_out       (data_out),
        .frame_opcode   (frame_opcode),
        .final_fragment (final_fragment),
        .frame_last     (frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: check accepted beats and stall in bursts, with quiet
    // stretches where nothing is held back.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(kind, data_out, frame_opcode, final_fragment, frame_last);
            rx_cycles++;
            if (rx_cycles % 300 == 0)
                quiet_rx = ($urandom_range(0, 2) == 0);
            if (stall_run > 0)
            begin
                stall_run--;
                result_stall <= 1'b1;
            end
            else if (quiet_rx)
                result_stall <= 1'b0;
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:69]:  result_stall <= 1'b0;
                    [70:94]:
                    begin
                        stall_run = $urandom_range(0, 2);
                        result_stall <= 1'b1;
                    end
                    default:
                    begin
                        stall_run = $urandom_range(10, 40);
                        result_stall <= 1'b1;
                    end
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic is_end);
        int gap;
        int r;
        gap = 0;
        if (gap_mode != 0)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(10, 40);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_in    <= value;
        buffer_end <= is_end;
        do
            @(posedge clk);
        while (byte_stall);
        sb.note_byte(value, is_end);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buf_q.size(); i++)
            send_byte(buf_q[i], i == buf_q.size() - 1);
    endtask

    // Hold the sender until every predicted result has come out.
    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void build_frame(input logic fin_bit, input logic [2:0] rsv,
                                        input logic [3:0] op, input logic masked,
                                        input int form, input logic [63:0] frame_len,
                                        input int payload_count);
        logic [6:0] len7;
        buf_q.delete();
        if (form == FORM_EXT16)
            len7 = LEN7_EXT16;
        else if (form == FORM_EXT64)
            len7 = LEN7_EXT64;
        else
            len7 = frame_len[6:0];
        buf_q.push_back({fin_bit, rsv, op});
        buf_q.push_back({masked, len7});
        if (form == FORM_EXT16)
        begin
            buf_q.push_back(frame_len[15:8]);
            buf_q.push_back(frame_len[7:0]);
        end
        if (form == FORM_EXT64)
            for (int i = 7; i >= 0; i--)
                buf_q.push_back(frame_len[8*i +: 8]);
        repeat (4) buf_q.push_back(8'($urandom));
        repeat (payload_count) buf_q.push_back(8'($urandom));
    endfunction

    initial
    begin
        int          r;
        int          form;
        int          payload_count;
        int          keep;
        int          buffers;
        logic        fin_bit;
        logic [2:0]  rsv;
        logic [3:0]  op;
        logic [63:0] frame_len;

        sb           = new();
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        data_in      = 8'h00;
        buffer_end   = 1'b0;
        result_stall = 1'b0;
        gap_mode     = 0;
        bytes_sent   = 0;
        stall_run    = 0;
        rx_cycles    = 0;
        quiet_rx     = 1'b1;
        buffers      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Zero-length masked frame.
        build_frame(1'b1, 3'b000, 4'h1, 1'b1, FORM_SHORT, 64'd0, 0);
        send_buffer();
        // Mask bit clear on a byte that also ends the buffer.
        build_frame(1'b0, 3'b111, 4'h2, 1'b0, FORM_SHORT, 64'd5, 0);
        while (buf_q.size() > 2)
            void'(buf_q.pop_back());
        send_buffer();
        // Buffer that ends on its first header byte.
        buf_q = '{8'hFF};
        send_buffer();
        // Ping one byte over the limit; the rest of the buffer is dropped.
        build_frame(1'b0, 3'b000, OPCODE_PING, 1'b1, FORM_EXT16, 64'd126, 0);
        send_buffer();
        // Largest 64-bit length, cut short inside the payload.
        build_frame(1'b1, 3'b000, 4'hF, 1'b1, FORM_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 2);
        send_buffer();
        wait_drained();

        while (bytes_sent < BYTE_TARGET)
        begin
            gap_mode = $urandom_range(0, 3);
            fin_bit  = 1'($urandom);
            rsv      = 3'($urandom);
            op       = ($urandom_range(0, 4) == 0) ? OPCODE_PING : 4'($urandom);
            r        = $urandom_range(0, 19);
            if (r < 14)
            begin
                form      = FORM_SHORT;
                frame_len = (op == OPCODE_PING && $urandom_range(0, 1) == 1) ?
                            64'($urandom_range(118, 125)) : 64'($urandom_range(0, 16));
            end
            else if (r < 18)
            begin
                form      = FORM_EXT16;
                frame_len = ($urandom_range(0, 1) == 1) ?
                            64'($urandom_range(120, 132)) : 64'($urandom_range(0, 40));
            end
            else
            begin
                form      = FORM_EXT64;
                frame_len = 64'($urandom_range(0, 24));
            end
            payload_count = int'(frame_len);

            r = $urandom_range(0, 99);
            if (r < 72)
            begin
                build_frame(fin_bit, rsv, op, 1'b1, form, frame_len, payload_count);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4)) buf_q.push_back(8'($urandom));
            end
            else if (r < 86)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    form          = ($urandom_range(0, 1) == 1) ? FORM_EXT64 : FORM_EXT16;
                    frame_len     = {$urandom, $urandom};
                    payload_count = $urandom_range(0, 6);
                end
                build_frame(fin_bit, rsv, op, 1'b1, form, frame_len, payload_count);
                keep = $urandom_range(1, buf_q.size() - 1);
                while (buf_q.size() > keep)
                    void'(buf_q.pop_back());
            end
            else if (r < 93)
            begin
                build_frame(fin_bit, rsv, op, 1'b0, form, frame_len, payload_count);
                if ($urandom_range(0, 1) == 1)
                begin
                    keep = $urandom_range(2, buf_q.size());
                    while (buf_q.size() > keep)
                        void'(buf_q.pop_back());
                end
            end
            else
            begin
                buf_q.delete();
                repeat ($urandom_range(1, 8)) buf_q.push_back(8'($urandom));
            end
            send_buffer();
            buffers++;
            if (buffers % 50 == 0)
                wait_drained();
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
